// ----- src/pet_pkg.sv -----
// pet_pkg: types, codes and sizes shared by the packed entity table
// used by pet_cmp and packed_entity_table; no dependencies
`timescale 1ns / 1ps

package pet_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int KEY_W       = 64;
  localparam int SLOT_W      = 6;

  typedef enum logic [1:0] {
    FUNC_CREATE  = 2'd0,
    FUNC_DESTROY = 2'd1,
    FUNC_LOOKUP  = 2'd2,
    FUNC_QUERY   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_NOMATCH  = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    CMP_ID   = 1'b0,
    CMP_MASK = 1'b1
  } cmp_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DEL_RD,
    S_DEL_WR
  } state_t;

  typedef struct packed {
    func_t              func;
    logic [KEY_W-1:0]   entity_id;
    logic [KEY_W-1:0]   flags;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [KEY_W-1:0]   entity_id_res;
    logic [KEY_W-1:0]   flags_res;
    logic [SLOT_W-1:0]  slot;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] id;
    logic [KEY_W-1:0] flags;
  } entry_t;

  function automatic out_item_t make_out(status_t st, entry_t ent, logic [SLOT_W-1:0] slot,
                                         logic last);
    out_item_t o;
    o.status        = st;
    o.entity_id_res = ent.id;
    o.flags_res     = ent.flags;
    o.slot          = slot;
    o.last          = last;
    return o;
  endfunction

endpackage

// ----- src/pet_ram.sv -----
// pet_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module pet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/pet_cmp.sv -----
// pet_cmp: the one 64-bit comparator shared by identifier search and mask query
// depends on pet_pkg
`timescale 1ns / 1ps

module pet_cmp (
  input  pet_pkg::cmp_op_t             op,
  input  logic [pet_pkg::KEY_W-1:0]    key,
  input  pet_pkg::entry_t              ent,
  output logic                         match
);

  logic [pet_pkg::KEY_W-1:0] lhs;

  // mask query: every key bit must be present in the stored flags
  always_comb begin
    unique case (op)
      pet_pkg::CMP_MASK: lhs = ent.flags & key;
      default:           lhs = ent.id;
    endcase
  end

  assign match = (lhs == key);

endmodule

// ----- src/packed_entity_table.sv -----
// packed_entity_table: top level, sequencer, entry count and result register
// depends on pet_pkg, pet_ram and pet_cmp
`timescale 1ns / 1ps

// A gap-free table of up to MAX_ENTRIES (identifier, flag mask) entries held in one
// ram. Raise start with an item while busy is low; busy stays high until the item is
// done. Every operation scans the filled entries one per cycle through the ram's single
// read port and the shared comparator. Create and query scan all n entries held, while a
// duplicate create, a destroy and a lookup stop at the hit; destroy then moves the last
// entry into the freed slot, through the states S_DEL_RD and S_DEL_WR. The next item is
// taken in the first cycle with busy low. Results appear on out_data for one cycle, marked
// by out_strobe, and cannot be held off; a query may give one result per entry, the final
// one with last set. There is no clearing pass after reset: the count starts at zero and
// only written entries are ever compared.

module packed_entity_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  pet_pkg::in_item_t  in_data,
  output logic               busy,
  output logic               out_strobe,
  output pet_pkg::out_item_t out_data
);

  pet_pkg::state_t                 state_r, state_nxt;
  logic [pet_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [pet_pkg::CNT_W-1:0]       rd_idx_r, rd_idx_nxt;
  logic                            vld_r, vld_nxt;
  logic                            pend_r, pend_nxt;
  logic                            out_strobe_r, out_strobe_nxt;

  pet_pkg::func_t                  func_r, func_nxt;
  logic [pet_pkg::KEY_W-1:0]       id_r, id_nxt;
  logic [pet_pkg::KEY_W-1:0]       fl_r, fl_nxt;
  logic [pet_pkg::IDX_W-1:0]       tag_r, tag_nxt;
  logic [pet_pkg::IDX_W-1:0]       hit_idx_r, hit_idx_nxt;
  pet_pkg::entry_t                 hit_ent_r, hit_ent_nxt;
  pet_pkg::out_item_t              out_data_r, out_data_nxt;

  logic                            ram_we;
  logic [pet_pkg::IDX_W-1:0]       ram_waddr;
  logic [pet_pkg::IDX_W-1:0]       ram_raddr;
  pet_pkg::entry_t                 ram_wdata;
  pet_pkg::entry_t                 rd_entry;

  pet_pkg::cmp_op_t                cmp_op;
  logic [pet_pkg::KEY_W-1:0]       cmp_key;
  logic                            cmp_match;

  logic                            hit;
  logic                            scan_more;
  logic                            scan_done;
  logic [pet_pkg::CNT_W-1:0]       last_idx;
  pet_pkg::entry_t                 in_ent;
  pet_pkg::entry_t                 nf_ent;

  pet_ram #(
    .WIDTH ($bits(pet_pkg::entry_t)),
    .DEPTH (pet_pkg::MAX_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_entry)
  );

  pet_cmp u_cmp (
    .op    (cmp_op),
    .key   (cmp_key),
    .ent   (rd_entry),
    .match (cmp_match)
  );

  assign cmp_op    = (func_r == pet_pkg::FUNC_QUERY) ? pet_pkg::CMP_MASK : pet_pkg::CMP_ID;
  assign cmp_key   = (func_r == pet_pkg::FUNC_QUERY) ? fl_r : id_r;
  assign hit       = vld_r && cmp_match;
  assign scan_more = (rd_idx_r < cnt_r);
  assign scan_done = !vld_r && !scan_more;
  assign last_idx  = cnt_r - pet_pkg::CNT_W'(1);
  assign in_ent    = '{id: id_r, flags: fl_r};
  assign nf_ent    = '{id: id_r, flags: '0};

  assign busy       = (state_r != pet_pkg::S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pet_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = pet_pkg::S_SCAN;
        end
      end
      pet_pkg::S_SCAN: begin
        if (hit && func_r != pet_pkg::FUNC_QUERY) begin
          state_nxt = (func_r == pet_pkg::FUNC_DESTROY) ? pet_pkg::S_DEL_RD : pet_pkg::S_IDLE;
        end else if (scan_done) begin
          state_nxt = pet_pkg::S_IDLE;
        end
      end
      pet_pkg::S_DEL_RD: state_nxt = pet_pkg::S_DEL_WR;
      pet_pkg::S_DEL_WR: state_nxt = pet_pkg::S_IDLE;
      default:           state_nxt = pet_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_nxt        = cnt_r;
    rd_idx_nxt     = rd_idx_r;
    vld_nxt        = 1'b0;
    pend_nxt       = pend_r;
    out_strobe_nxt = 1'b0;
    func_nxt       = func_r;
    id_nxt         = id_r;
    fl_nxt         = fl_r;
    tag_nxt        = tag_r;
    hit_idx_nxt    = hit_idx_r;
    hit_ent_nxt    = hit_ent_r;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_waddr      = hit_idx_r;
    ram_wdata      = rd_entry;
    ram_raddr      = rd_idx_r[pet_pkg::IDX_W-1:0];

    unique case (state_r)
      pet_pkg::S_IDLE: begin
        if (start) begin
          func_nxt   = in_data.func;
          id_nxt     = in_data.entity_id;
          fl_nxt     = in_data.flags;
          rd_idx_nxt = '0;
          pend_nxt   = 1'b0;
        end
      end

      pet_pkg::S_SCAN: begin
        // one read issued per cycle, data comes back in the next cycle with its tag
        if (scan_more) begin
          vld_nxt    = 1'b1;
          tag_nxt    = rd_idx_r[pet_pkg::IDX_W-1:0];
          rd_idx_nxt = rd_idx_r + pet_pkg::CNT_W'(1);
        end

        if (hit) begin
          if (func_r == pet_pkg::FUNC_QUERY) begin
            // a match is held back until we know whether another follows
            if (pend_r) begin
              out_strobe_nxt = 1'b1;
              out_data_nxt   = pet_pkg::make_out(pet_pkg::ST_OK, hit_ent_r,
                                                 pet_pkg::SLOT_W'(hit_idx_r), 1'b0);
            end
            pend_nxt    = 1'b1;
            hit_ent_nxt = rd_entry;
            hit_idx_nxt = tag_r;
          end else begin
            out_strobe_nxt = 1'b1;
            out_data_nxt   = pet_pkg::make_out(
                               (func_r == pet_pkg::FUNC_CREATE) ? pet_pkg::ST_DUP : pet_pkg::ST_OK,
                               rd_entry, pet_pkg::SLOT_W'(tag_r), 1'b1);
            hit_idx_nxt    = tag_r;
          end
        end else if (scan_done) begin
          out_strobe_nxt = 1'b1;
          unique case (func_r) inside
            pet_pkg::FUNC_CREATE: begin
              if (cnt_r == pet_pkg::CNT_W'(pet_pkg::MAX_ENTRIES)) begin
                out_data_nxt = pet_pkg::make_out(pet_pkg::ST_FULL, in_ent, '0, 1'b1);
              end else begin
                ram_we       = 1'b1;
                ram_waddr    = cnt_r[pet_pkg::IDX_W-1:0];
                ram_wdata    = in_ent;
                cnt_nxt      = cnt_r + pet_pkg::CNT_W'(1);
                out_data_nxt = pet_pkg::make_out(pet_pkg::ST_OK, in_ent,
                                                 pet_pkg::SLOT_W'(cnt_r), 1'b1);
              end
            end
            pet_pkg::FUNC_DESTROY, pet_pkg::FUNC_LOOKUP: begin
              out_data_nxt = pet_pkg::make_out(pet_pkg::ST_NOTFOUND, nf_ent, '0, 1'b1);
            end
            pet_pkg::FUNC_QUERY: begin
              if (pend_r) begin
                out_data_nxt = pet_pkg::make_out(pet_pkg::ST_OK, hit_ent_r,
                                                 pet_pkg::SLOT_W'(hit_idx_r), 1'b1);
              end else begin
                out_data_nxt = pet_pkg::make_out(pet_pkg::ST_NOMATCH, '0, '0, 1'b1);
              end
            end
            default: begin
              out_data_nxt = pet_pkg::make_out(pet_pkg::ST_NOMATCH, '0, '0, 1'b1);
            end
          endcase
        end
      end

      pet_pkg::S_DEL_RD: begin
        ram_raddr = last_idx[pet_pkg::IDX_W-1:0];
      end

      pet_pkg::S_DEL_WR: begin
        // last entry fills the freed slot
        ram_we    = 1'b1;
        ram_waddr = hit_idx_r;
        ram_wdata = rd_entry;
        cnt_nxt   = last_idx;
      end

      default: begin
        vld_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pet_pkg::S_IDLE;
      cnt_r        <= '0;
      rd_idx_r     <= '0;
      vld_r        <= 1'b0;
      pend_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      rd_idx_r     <= rd_idx_nxt;
      vld_r        <= vld_nxt;
      pend_r       <= pend_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    id_r       <= id_nxt;
    fl_r       <= fl_nxt;
    tag_r      <= tag_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_ent_r  <= hit_ent_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= pet_pkg::CNT_W'(pet_pkg::MAX_ENTRIES))
    else $error("entry count beyond table size");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> (pet_pkg::CNT_W'(tag_r) < cnt_r))
    else $error("scan read beyond filled entries");

  a_strobe_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(state_r == pet_pkg::S_SCAN))
    else $error("result strobe without a scan behind it");

  a_destroy_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pet_pkg::S_DEL_WR |=> cnt_r == $past(cnt_r) - pet_pkg::CNT_W'(1))
    else $error("destroy did not shrink the table by one");
`endif

endmodule

// ----- verif/packed_entity_table_tb.sv -----
// packed_entity_table_tb: self-checking bench for the packed entity table
// drives create, destroy, lookup and mask-query items against a mirrored table
// depends on pet_pkg and packed_entity_table
`timescale 1ns / 1ps

module packed_entity_table_tb;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 150;
  localparam logic [pet_pkg::KEY_W-1:0] ALL_ONES = {pet_pkg::KEY_W{1'b1}};
  localparam logic [pet_pkg::KEY_W-1:0] ALT_HI   = {(pet_pkg::KEY_W/2){2'b10}};
  localparam logic [pet_pkg::KEY_W-1:0] ALT_LO   = {(pet_pkg::KEY_W/2){2'b01}};

  logic               clk     = 1'b0;
  logic               rst_n   = 1'b0;
  logic               start   = 1'b0;
  pet_pkg::in_item_t  in_data = '0;
  logic               busy;
  logic               out_strobe;
  pet_pkg::out_item_t out_data;

  // mirror of the table contents
  logic [pet_pkg::KEY_W-1:0] mirror_ids   [pet_pkg::MAX_ENTRIES];
  logic [pet_pkg::KEY_W-1:0] mirror_flags [pet_pkg::MAX_ENTRIES];
  int                        mirror_count = 0;

  pet_pkg::out_item_t pending_results[$];
  int                 mismatches = 0;
  int                 cycles     = 0;
  bit                 gaps_on    = 1'b1;

  packed_entity_table uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_data    (in_data),
    .busy       (busy),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [pet_pkg::KEY_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int locate_id(logic [pet_pkg::KEY_W-1:0] id);
    for (int i = 0; i < mirror_count; i++)
      if (mirror_ids[i] == id) return i;
    return -1;
  endfunction

  function automatic pet_pkg::out_item_t result_of(pet_pkg::status_t st,
                                                   logic [pet_pkg::KEY_W-1:0] id,
                                                   logic [pet_pkg::KEY_W-1:0] fl,
                                                   int slot, logic last);
    pet_pkg::out_item_t r;
    r.status        = st;
    r.entity_id_res = id;
    r.flags_res     = fl;
    r.slot          = slot[pet_pkg::SLOT_W-1:0];
    r.last          = last;
    return r;
  endfunction

  function automatic void predict_table_op(pet_pkg::in_item_t it);
    int hit;
    int tail;
    int matched[$];
    hit = locate_id(it.entity_id);
    case (it.func) inside
      pet_pkg::FUNC_CREATE: begin
        if (hit >= 0) begin
          pending_results.push_back(result_of(pet_pkg::ST_DUP, mirror_ids[hit],
                                              mirror_flags[hit], hit, 1'b1));
        end else if (mirror_count >= pet_pkg::MAX_ENTRIES) begin
          pending_results.push_back(result_of(pet_pkg::ST_FULL, it.entity_id, it.flags, 0,
                                              1'b1));
        end else begin
          mirror_ids[mirror_count]   = it.entity_id;
          mirror_flags[mirror_count] = it.flags;
          pending_results.push_back(result_of(pet_pkg::ST_OK, it.entity_id, it.flags,
                                              mirror_count, 1'b1));
          mirror_count++;
        end
      end
      pet_pkg::FUNC_DESTROY, pet_pkg::FUNC_LOOKUP: begin
        if (hit < 0) begin
          pending_results.push_back(result_of(pet_pkg::ST_NOTFOUND, it.entity_id, '0, 0,
                                              1'b1));
        end else begin
          pending_results.push_back(result_of(pet_pkg::ST_OK, mirror_ids[hit],
                                              mirror_flags[hit], hit, 1'b1));
          // swap-remove: the tail entry fills the hole
          if (it.func == pet_pkg::FUNC_DESTROY) begin
            tail              = mirror_count - 1;
            mirror_ids[hit]   = mirror_ids[tail];
            mirror_flags[hit] = mirror_flags[tail];
            mirror_count      = tail;
          end
        end
      end
      pet_pkg::FUNC_QUERY: begin
        for (int i = 0; i < mirror_count; i++)
          if ((mirror_flags[i] & it.flags) == it.flags) matched.push_back(i);
        if (matched.size() == 0)
          pending_results.push_back(result_of(pet_pkg::ST_NOMATCH, '0, '0, 0, 1'b1));
        for (int k = 0; k < matched.size(); k++)
          pending_results.push_back(result_of(pet_pkg::ST_OK, mirror_ids[matched[k]],
                                              mirror_flags[matched[k]], matched[k],
                                              k == matched.size() - 1));
      end
    endcase
  endfunction

  function automatic void note_failure(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin : result_check
    pet_pkg::out_item_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result: status %0d id %h flags %h slot %0d last %0b",
                               out_data.status, out_data.entity_id_res, out_data.flags_res,
                               out_data.slot, out_data.last));
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status || out_data.entity_id_res !== want.entity_id_res ||
            out_data.flags_res !== want.flags_res || out_data.slot !== want.slot ||
            out_data.last !== want.last)
          note_failure($sformatf({"mismatch: expected status %0d id %h flags %h slot %0d ",
                                  "last %0b, got status %0d id %h flags %h slot %0d last %0b"},
                                 want.status, want.entity_id_res, want.flags_res, want.slot,
                                 want.last, out_data.status, out_data.entity_id_res,
                                 out_data.flags_res, out_data.slot, out_data.last));
      end
    end
  end

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // start stays high after acceptance until the next falling edge changes it
  task automatic send_item(pet_pkg::func_t fn, logic [pet_pkg::KEY_W-1:0] id,
                           logic [pet_pkg::KEY_W-1:0] fl);
    pet_pkg::in_item_t it;
    it.func      = fn;
    it.entity_id = id;
    it.flags     = fl;
    if (gaps_on && $urandom_range(99) < 12) idle_cycles($urandom_range(5, 1));
    @(negedge clk);
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    predict_table_op(it);
  endtask

  function automatic logic [pet_pkg::KEY_W-1:0] random_flags();
    int roll;
    roll = $urandom_range(99);
    if (roll < 50) return rand64();
    if (roll < 75) return rand64() | rand64();
    return rand64() & rand64();
  endfunction

  function automatic logic [pet_pkg::KEY_W-1:0] held_or_stray_id();
    if (mirror_count > 0 && $urandom_range(99) < 85)
      return mirror_ids[$urandom_range(mirror_count - 1)];
    return rand64();
  endfunction

  // masks: zero, random, stored flags or two set bits, so queries often match
  function automatic logic [pet_pkg::KEY_W-1:0] query_mask();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 25) return rand64();
    if (roll < 55 && mirror_count > 0) return mirror_flags[$urandom_range(mirror_count - 1)];
    return (64'd1 << $urandom_range(63)) | (64'd1 << $urandom_range(63));
  endfunction

  task automatic random_ops(int n, int create_pct, int destroy_pct, int lookup_pct,
                            int quiet_from);
    int roll;
    logic [pet_pkg::KEY_W-1:0] id;
    for (int k = 0; k < n; k++) begin
      gaps_on = !(k >= quiet_from && k < quiet_from + 60);
      roll    = $urandom_range(99);
      if (roll < create_pct) begin
        if (mirror_count > 0 && $urandom_range(99) < 20)
          id = mirror_ids[$urandom_range(mirror_count - 1)];
        else
          id = rand64();
        send_item(pet_pkg::FUNC_CREATE, id, random_flags());
      end else if (roll < create_pct + destroy_pct) begin
        send_item(pet_pkg::FUNC_DESTROY, held_or_stray_id(), rand64());
      end else if (roll < create_pct + destroy_pct + lookup_pct) begin
        send_item(pet_pkg::FUNC_LOOKUP, held_or_stray_id(), rand64());
      end else begin
        send_item(pet_pkg::FUNC_QUERY, rand64(), query_mask());
      end
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_directed_cases();
    // empty table
    send_item(pet_pkg::FUNC_QUERY, '0, '0);
    send_item(pet_pkg::FUNC_LOOKUP, '0, ALL_ONES);
    send_item(pet_pkg::FUNC_DESTROY, ALL_ONES, '0);
    // extremes of identifier and flags
    send_item(pet_pkg::FUNC_CREATE, '0, '0);
    send_item(pet_pkg::FUNC_CREATE, ALL_ONES, ALL_ONES);
    send_item(pet_pkg::FUNC_CREATE, ALT_LO, ALT_HI);
    send_item(pet_pkg::FUNC_CREATE, ALT_HI, ALT_LO);
    // duplicates report the stored entry
    send_item(pet_pkg::FUNC_CREATE, '0, ALL_ONES);
    send_item(pet_pkg::FUNC_CREATE, ALL_ONES, rand64());
    send_item(pet_pkg::FUNC_LOOKUP, ALL_ONES, '0);
    send_item(pet_pkg::FUNC_LOOKUP, 64'd123, '0);
    send_item(pet_pkg::FUNC_QUERY, ALL_ONES, '0);
    send_item(pet_pkg::FUNC_QUERY, '0, ALL_ONES);
    send_item(pet_pkg::FUNC_QUERY, rand64(), ALT_HI);
    send_item(pet_pkg::FUNC_QUERY, rand64(), {1'b1, 62'd0, 1'b1});
    // remove from the head, then the tail entry
    send_item(pet_pkg::FUNC_DESTROY, '0, '0);
    send_item(pet_pkg::FUNC_LOOKUP, ALT_HI, '0);
    send_item(pet_pkg::FUNC_DESTROY, mirror_ids[mirror_count - 1], ALL_ONES);
    send_item(pet_pkg::FUNC_DESTROY, 64'd123, '0);
    send_item(pet_pkg::FUNC_QUERY, '0, '0);
    send_item(pet_pkg::FUNC_DESTROY, ALL_ONES, '0);
    send_item(pet_pkg::FUNC_QUERY, '0, ALL_ONES);
  endtask

  // create-heavy mix: the table reaches full and stays there for a while
  task automatic test_table_fill();
    random_ops(200, 68, 10, 12, 40);
  endtask

  // destroy-heavy mix: the table empties again
  task automatic test_table_drain();
    random_ops(150, 18, 57, 15, 70);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    wait_all_results();
    test_table_fill();
    wait_all_results();
    test_table_drain();
    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
